[hdl/prr_pkg.sv]
// shared constants, types and fixed-point helpers for the reprojection residual block
`default_nettype none

package prr_pkg;

	// field widths
	localparam int CoordW = 32;
	localparam int PixW   = 26;
	localparam int WgtW   = 24;
	localparam int ProdW  = 36;
	localparam int C1W    = 34;
	localparam int CamW   = 37;
	localparam int MulW   = 63;
	localparam int NumW   = 62;
	localparam int DenW   = 37;
	localparam int QuoW   = 53;
	localparam int DiffW  = 56;
	localparam int ClipW  = 49;
	localparam int LoW    = 25;

	// intrinsics in Q16.16, rounded to nearest
	localparam logic signed [25:0] FX_Q16 = 26'sd24742151;
	localparam logic signed [25:0] FY_Q16 = 26'sd24720824;
	localparam logic [24:0] CX_Q16 = 25'd21508481;
	localparam logic [24:0] CY_Q16 = 25'd15756616;

	// depth limit of 0.01 m in Q16.16 units
	localparam logic signed [CamW-1:0] DEPTH_MIN_Q16 = 37'sd655;
	localparam logic [7:0] PENALTY = 8'd100;
	localparam logic signed [31:0] Q_ONE = 32'sd1073741824;

	// configuration register indexes
	localparam logic [2:0] CFG_TRANS_X = 3'd0;
	localparam logic [2:0] CFG_TRANS_Y = 3'd1;
	localparam logic [2:0] CFG_TRANS_Z = 3'd2;
	localparam logic [2:0] CFG_QUAT_X  = 3'd3;
	localparam logic [2:0] CFG_QUAT_Y  = 3'd4;
	localparam logic [2:0] CFG_QUAT_Z  = 3'd5;
	localparam logic [2:0] CFG_QUAT_W  = 3'd6;

	// sideband that rides along the divider
	typedef struct packed {
		logic            behind;
		logic [WgtW-1:0] weight;
		logic [PixW-1:0] obs_u;
		logic [PixW-1:0] obs_v;
		logic            neg_u;
		logic            neg_v;
	} prr_side_t;

	// limit a quaternion component to [-1.0, +1.0]
	function automatic logic signed [31:0] clamp_q(input logic signed [31:0] q);
		logic signed [31:0] r;
		r = q;
		if (q > Q_ONE) r = Q_ONE;
		if (q < -Q_ONE) r = -Q_ONE;
		return r;
	endfunction

	// Q2.30 times Q16.16, scaled by 2^-30 rounding toward minus infinity
	function automatic logic signed [ProdW-1:0] qmul(input logic signed [31:0] q,
		input logic signed [34:0] x);
		logic signed [66:0] p;
		p = 67'(q) * 67'(x);
		return p[65:30];
	endfunction

endpackage

`default_nettype wire

[hdl/prr_div.sv]
// pipelined restoring divider, one quotient bit per stage, two lanes sharing a divisor
`default_nettype none

module prr_div (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_valid,
	input  logic [prr_pkg::NumW-1:0] in_num_u,
	input  logic [prr_pkg::NumW-1:0] in_num_v,
	input  logic [prr_pkg::DenW-1:0] in_den,
	input  prr_pkg::prr_side_t       in_side,
	output logic                     out_valid,
	output logic [prr_pkg::NumW-1:0] out_quo_u,
	output logic [prr_pkg::NumW-1:0] out_quo_v,
	output prr_pkg::prr_side_t       out_side
);
	import prr_pkg::*;

	typedef struct packed {
		logic [DenW-1:0] rem_u;
		logic [NumW-1:0] num_u;
		logic [DenW-1:0] rem_v;
		logic [NumW-1:0] num_v;
		logic [DenW-1:0] den;
		prr_side_t       side;
	} div_stage_t;

	div_stage_t stg_s [1:NumW];
	logic       vld_s [1:NumW];
	div_stage_t stg_in;

	// one restoring step: shift in the next dividend bit, subtract if it fits
	function automatic logic [DenW+NumW-1:0] div_step(input logic [DenW-1:0] rem,
		input logic [NumW-1:0] num, input logic [DenW-1:0] den);
		logic [DenW:0]        trial;
		logic [DenW:0]        diff;
		logic [DenW+NumW-1:0] res;
		trial = {rem, num[NumW-1]};
		diff  = trial - {1'b0, den};
		if (trial >= {1'b0, den}) begin
			res = {diff[DenW-1:0], num[NumW-2:0], 1'b1};
		end else begin
			res = {trial[DenW-1:0], num[NumW-2:0], 1'b0};
		end
		return res;
	endfunction

	assign stg_in = '{rem_u: '0, num_u: in_num_u, rem_v: '0, num_v: in_num_v,
		den: in_den, side: in_side};

	// quotient bits enter at the bottom of the dividend word as it shifts out
	for (genvar k = 0; k < NumW; k++) begin : g_stage
		div_stage_t           cur;
		logic                 cur_v;
		logic [DenW+NumW-1:0] nu;
		logic [DenW+NumW-1:0] nv;

		if (k == 0) begin : g_first
			assign cur   = stg_in;
			assign cur_v = in_valid;
		end else begin : g_next
			assign cur   = stg_s[k];
			assign cur_v = vld_s[k];
		end

		assign nu = div_step(cur.rem_u, cur.num_u, cur.den);
		assign nv = div_step(cur.rem_v, cur.num_v, cur.den);

		// stage valid
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= cur_v;
			end
		end

		// stage payload
		always_ff @(posedge clk) begin
			if (en) begin
				stg_s[k+1].rem_u <= nu[DenW+NumW-1:NumW];
				stg_s[k+1].num_u <= nu[NumW-1:0];
				stg_s[k+1].rem_v <= nv[DenW+NumW-1:NumW];
				stg_s[k+1].num_v <= nv[NumW-1:0];
				stg_s[k+1].den   <= cur.den;
				stg_s[k+1].side  <= cur.side;
			end
		end
	end

	assign out_valid = vld_s[NumW];
	assign out_quo_u = stg_s[NumW].num_u;
	assign out_quo_v = stg_s[NumW].num_v;
	assign out_side  = stg_s[NumW].side;

endmodule

`default_nettype wire

[hdl/pinhole_reprojection_residual.sv]
// top level: pinhole camera reprojection residual pipeline
// Usage:
// Configuration writes on cfg_valid/cfg_ready (always ready) set the camera
// translation (Q16.16) and rotation quaternion (Q2.30) by register index.
// Write them only while no transaction is in flight.
// Each slave transaction carries a world point, the observed pixel and the
// square root of the weight; each one yields exactly one master transaction
// with the weighted u and v residuals in m_tdata and the behind-camera flag
// in m_tuser.
// The pipeline has 7 stages for rotation, translation and the
// intrinsics product, 62 stages of the bit-per-stage divider and 3 stages
// for weighting, saturation and the output register.
// Throughput is one transaction per cycle; the whole pipeline advances when
// the output register is empty or being taken.
// When the receiver stalls, every stage holds and s_tready drops, so no
// transaction is lost or repeated.
// Reset clears all valid bits and sets translation to zero and the
// quaternion to identity.
`default_nettype none

module pinhole_reprojection_residual (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// point_x, point_y, point_z, observed_u, observed_v, root_weight, zero pad
	input  logic [175:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// residual_u, residual_v
	output logic [63:0]  m_tdata,
	// behind_camera
	output logic [0:0]   m_tuser,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data
);
	import prr_pkg::*;

	logic en;

	// configuration registers
	logic signed [31:0] trans_x_q, trans_y_q, trans_z_q;
	logic signed [31:0] quat_x_q, quat_y_q, quat_z_q, quat_w_q;

	// stage 1
	logic                     v_s1;
	logic signed [CoordW-1:0] px_s1, py_s1, pz_s1;
	logic [PixW-1:0]          ou_s1, ov_s1;
	logic [WgtW-1:0]          w_s1;
	// stage 2
	logic                     v_s2;
	logic signed [CoordW-1:0] px_s2, py_s2, pz_s2;
	logic [PixW-1:0]          ou_s2, ov_s2;
	logic [WgtW-1:0]          w_s2;
	logic signed [ProdW-1:0]  a1_s2, b1_s2, a2_s2, b2_s2, a3_s2, b3_s2;
	// stage 3
	logic                     v_s3;
	logic signed [CoordW-1:0] px_s3, py_s3, pz_s3;
	logic [PixW-1:0]          ou_s3, ov_s3;
	logic [WgtW-1:0]          w_s3;
	logic signed [C1W-1:0]    c1x_s3, c1y_s3, c1z_s3;
	// stage 4
	logic                     v_s4;
	logic signed [CoordW-1:0] px_s4, py_s4, pz_s4;
	logic [PixW-1:0]          ou_s4, ov_s4;
	logic [WgtW-1:0]          w_s4;
	logic signed [ProdW-1:0]  wx_s4, wy_s4, wz_s4;
	logic signed [ProdW-1:0]  dxa_s4, dxb_s4, dya_s4, dyb_s4, dza_s4, dzb_s4;
	// stage 5
	logic                     v_s5;
	logic [PixW-1:0]          ou_s5, ov_s5;
	logic [WgtW-1:0]          w_s5;
	logic signed [CamW-1:0]   xc_s5, yc_s5, zc_s5;
	// stage 6
	logic                     v_s6;
	logic [PixW-1:0]          ou_s6, ov_s6;
	logic [WgtW-1:0]          w_s6;
	logic signed [MulW-1:0]   nx_s6, ny_s6;
	logic signed [CamW-1:0]   zc_s6;
	logic                     behind_s6;
	// stage 7
	logic                     v_s7;
	logic [NumW-1:0]          mu_s7, mv_s7;
	logic [DenW-1:0]          den_s7;
	prr_side_t                side_s7;
	// divider output
	logic                     dv_valid;
	logic [NumW-1:0]          dv_quo_u, dv_quo_v;
	prr_side_t                dv_side;
	// stage 8
	logic                     v_s8;
	logic signed [ClipW-1:0]  du_s8, dv_s8;
	logic [WgtW-1:0]          w_s8;
	logic                     behind_s8;
	// stage 9
	logic                     v_s9;
	logic [ClipW-1:0]         plu_s9, plv_s9;
	logic signed [ClipW-1:0]  phu_s9, phv_s9;
	logic [WgtW-1:0]          w_s9;
	logic                     behind_s9;
	// output register
	logic                     out_valid_q;
	logic [63:0]              out_data_q;
	logic                     out_behind_q;

	logic signed [DiffW-1:0]  diff_u, diff_v;
	logic signed [73:0]       tot_u, tot_v;
	logic [31:0]              pen;

	// signed projection minus observation, clipped where the result saturates anyway
	function automatic logic signed [ClipW-1:0] proj_diff(input logic [NumW-1:0] quo,
		input logic neg, input logic [24:0] center, input logic [PixW-1:0] obs);
		logic signed [DiffW-1:0] mag;
		logic signed [DiffW-1:0] d;
		logic signed [ClipW-1:0] r;
		mag = $signed({3'b000, quo[QuoW-1:0]});
		d   = (neg ? -mag : mag) + $signed({31'b0, center}) - $signed({30'b0, obs});
		r   = d[ClipW-1:0];
		if (d > $signed({{(DiffW-ClipW+1){1'b0}}, {(ClipW-1){1'b1}}})) begin
			r = {1'b0, {(ClipW-1){1'b1}}};
		end else if (d < -$signed({{(DiffW-ClipW){1'b0}}, 1'b1, {(ClipW-1){1'b0}}})) begin
			r = {1'b1, {(ClipW-1){1'b0}}};
		end
		return r;
	endfunction

	// floor by 2^16 and saturate to 32 bits
	function automatic logic [31:0] scale_sat(input logic signed [73:0] t);
		logic signed [57:0] s;
		logic [31:0]        r;
		s = t[73:16];
		r = s[31:0];
		if (s > 58'sd2147483647) r = 32'h7fffffff;
		else if (s < -58'sd2147483648) r = 32'h80000000;
		return r;
	endfunction

	assign en        = !out_valid_q || m_tready;
	assign s_tready  = en;
	assign cfg_ready = 1'b1;

	// configuration writes, quaternion limited on the way in
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trans_x_q <= '0;
			trans_y_q <= '0;
			trans_z_q <= '0;
			quat_x_q  <= '0;
			quat_y_q  <= '0;
			quat_z_q  <= '0;
			quat_w_q  <= Q_ONE;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_TRANS_X: trans_x_q <= cfg_data;
				CFG_TRANS_Y: trans_y_q <= cfg_data;
				CFG_TRANS_Z: trans_z_q <= cfg_data;
				CFG_QUAT_X:  quat_x_q  <= clamp_q(cfg_data);
				CFG_QUAT_Y:  quat_y_q  <= clamp_q(cfg_data);
				CFG_QUAT_Z:  quat_z_q  <= clamp_q(cfg_data);
				CFG_QUAT_W:  quat_w_q  <= clamp_q(cfg_data);
				default: ;
			endcase
		end
	end

	// valid chain ahead of the divider
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (en) begin
			px_s1 <= s_tdata[31:0];
			py_s1 <= s_tdata[63:32];
			pz_s1 <= s_tdata[95:64];
			ou_s1 <= s_tdata[121:96];
			ov_s1 <= s_tdata[147:122];
			w_s1  <= s_tdata[171:148];
		end
	end

	// first cross product terms v x p
	always_ff @(posedge clk) begin
		if (en) begin
			px_s2 <= px_s1;
			py_s2 <= py_s1;
			pz_s2 <= pz_s1;
			ou_s2 <= ou_s1;
			ov_s2 <= ov_s1;
			w_s2  <= w_s1;
			a1_s2 <= qmul(quat_y_q, 35'(pz_s1));
			b1_s2 <= qmul(quat_z_q, 35'(py_s1));
			a2_s2 <= qmul(quat_z_q, 35'(px_s1));
			b2_s2 <= qmul(quat_x_q, 35'(pz_s1));
			a3_s2 <= qmul(quat_x_q, 35'(py_s1));
			b3_s2 <= qmul(quat_y_q, 35'(px_s1));
		end
	end

	// first cross product
	always_ff @(posedge clk) begin
		if (en) begin
			px_s3  <= px_s2;
			py_s3  <= py_s2;
			pz_s3  <= pz_s2;
			ou_s3  <= ou_s2;
			ov_s3  <= ov_s2;
			w_s3   <= w_s2;
			c1x_s3 <= C1W'(a1_s2 - b1_s2);
			c1y_s3 <= C1W'(a2_s2 - b2_s2);
			c1z_s3 <= C1W'(a3_s2 - b3_s2);
		end
	end

	// scalar term and second cross product terms
	always_ff @(posedge clk) begin
		if (en) begin
			px_s4  <= px_s3;
			py_s4  <= py_s3;
			pz_s4  <= pz_s3;
			ou_s4  <= ou_s3;
			ov_s4  <= ov_s3;
			w_s4   <= w_s3;
			wx_s4  <= qmul(quat_w_q, 35'(c1x_s3));
			wy_s4  <= qmul(quat_w_q, 35'(c1y_s3));
			wz_s4  <= qmul(quat_w_q, 35'(c1z_s3));
			dxa_s4 <= qmul(quat_y_q, 35'(c1z_s3));
			dxb_s4 <= qmul(quat_z_q, 35'(c1y_s3));
			dya_s4 <= qmul(quat_z_q, 35'(c1x_s3));
			dyb_s4 <= qmul(quat_x_q, 35'(c1z_s3));
			dza_s4 <= qmul(quat_x_q, 35'(c1y_s3));
			dzb_s4 <= qmul(quat_y_q, 35'(c1x_s3));
		end
	end

	// camera coordinates
	always_ff @(posedge clk) begin
		if (en) begin
			ou_s5 <= ou_s4;
			ov_s5 <= ov_s4;
			w_s5  <= w_s4;
			xc_s5 <= CamW'(px_s4) + (CamW'(wx_s4) <<< 1)
				+ ((CamW'(dxa_s4) - CamW'(dxb_s4)) <<< 1) + CamW'(trans_x_q);
			yc_s5 <= CamW'(py_s4) + (CamW'(wy_s4) <<< 1)
				+ ((CamW'(dya_s4) - CamW'(dyb_s4)) <<< 1) + CamW'(trans_y_q);
			zc_s5 <= CamW'(pz_s4) + (CamW'(wz_s4) <<< 1)
				+ ((CamW'(dza_s4) - CamW'(dzb_s4)) <<< 1) + CamW'(trans_z_q);
		end
	end

	// focal length products and depth test
	always_ff @(posedge clk) begin
		if (en) begin
			ou_s6     <= ou_s5;
			ov_s6     <= ov_s5;
			w_s6      <= w_s5;
			nx_s6     <= MulW'(xc_s5) * MulW'(FX_Q16);
			ny_s6     <= MulW'(yc_s5) * MulW'(FY_Q16);
			zc_s6     <= zc_s5;
			behind_s6 <= zc_s5 <= DEPTH_MIN_Q16;
		end
	end

	// split into sign and magnitude for the divider
	always_ff @(posedge clk) begin
		if (en) begin
			mu_s7          <= nx_s6[MulW-1] ? NumW'(-nx_s6) : NumW'(nx_s6);
			mv_s7          <= ny_s6[MulW-1] ? NumW'(-ny_s6) : NumW'(ny_s6);
			den_s7         <= zc_s6[DenW-1:0];
			side_s7.behind <= behind_s6;
			side_s7.weight <= w_s6;
			side_s7.obs_u  <= ou_s6;
			side_s7.obs_v  <= ov_s6;
			side_s7.neg_u  <= nx_s6[MulW-1];
			side_s7.neg_v  <= ny_s6[MulW-1];
		end
	end

	prr_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s7),
		.in_num_u  (mu_s7),
		.in_num_v  (mv_s7),
		.in_den    (den_s7),
		.in_side   (side_s7),
		.out_valid (dv_valid),
		.out_quo_u (dv_quo_u),
		.out_quo_v (dv_quo_v),
		.out_side  (dv_side)
	);

	// valid chain behind the divider
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8        <= 1'b0;
			v_s9        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s8        <= dv_valid;
			v_s9        <= v_s8;
			out_valid_q <= v_s9;
		end
	end

	// pixel differences
	always_ff @(posedge clk) begin
		if (en) begin
			du_s8     <= proj_diff(dv_quo_u, dv_side.neg_u, CX_Q16, dv_side.obs_u);
			dv_s8     <= proj_diff(dv_quo_v, dv_side.neg_v, CY_Q16, dv_side.obs_v);
			w_s8      <= dv_side.weight;
			behind_s8 <= dv_side.behind;
		end
	end

	// weight products, split into low and high partial products
	always_ff @(posedge clk) begin
		if (en) begin
			plu_s9    <= ClipW'(du_s8[LoW-1:0]) * ClipW'(w_s8);
			plv_s9    <= ClipW'(dv_s8[LoW-1:0]) * ClipW'(w_s8);
			phu_s9    <= ClipW'($signed(du_s8[ClipW-1:LoW])) * ClipW'($signed({1'b0, w_s8}));
			phv_s9    <= ClipW'($signed(dv_s8[ClipW-1:LoW])) * ClipW'($signed({1'b0, w_s8}));
			w_s9      <= w_s8;
			behind_s9 <= behind_s8;
		end
	end

	assign tot_u = $signed({phu_s9, {LoW{1'b0}}}) + $signed({{LoW{1'b0}}, plu_s9});
	assign tot_v = $signed({phv_s9, {LoW{1'b0}}}) + $signed({{LoW{1'b0}}, plv_s9});
	assign pen   = {8'b0, w_s9} * {24'b0, PENALTY};

	// output register: penalty or saturated residuals
	always_ff @(posedge clk) begin
		if (en) begin
			out_behind_q <= behind_s9;
			if (behind_s9) begin
				out_data_q <= {pen, pen};
			end else begin
				out_data_q <= {scale_sat(tot_v), scale_sat(tot_u)};
			end
		end
	end

	assign m_tvalid   = out_valid_q;
	assign m_tdata    = out_data_q;
	assign m_tuser[0] = out_behind_q;

`ifndef SYNTH
	// penalty results carry the same value in both lanes
	a_pen_equal: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[31:0] == m_tdata[63:32])
		else $error("penalty residuals differ");

	// penalty results are never negative
	a_pen_sign: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> !m_tdata[31])
		else $error("negative penalty residual");

	// a stalled pipeline keeps its first stage
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(v_s1))
		else $error("first stage moved during stall");

	// an item in stage 9 reaches the output register whenever the pipeline advances
	a_tail: assert property (@(posedge clk) disable iff (!arst_n)
		en && v_s9 |=> out_valid_q)
		else $error("item lost before output register");
`endif

endmodule

`default_nettype wire

[tb/prr_checker.sv]
// checker for the reprojection residual block: tracks config, predicts residuals, compares
`timescale 1ns / 100ps
`default_nettype none

module prr_checker (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	input  wire logic         s_tready,
	input  wire logic [175:0] s_tdata,
	input  wire logic         m_tvalid,
	input  wire logic         m_tready,
	input  wire logic [63:0]  m_tdata,
	input  wire logic [0:0]   m_tuser,
	input  wire logic         cfg_valid,
	input  wire logic         cfg_ready,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [31:0]  cfg_data,
	output int                errors,
	output int                outstanding
);
	import prr_pkg::*;

	typedef struct {
		logic [31:0] res_u;
		logic [31:0] res_v;
		logic        behind;
	} residual_t;

	residual_t pending_residuals[$];

	// camera pose as the block should hold it
	longint cam_tx, cam_ty, cam_tz, cam_qx, cam_qy, cam_qz, cam_qw;

	function automatic longint limit_unit(longint q);
		if (q > 64'sd1073741824) return 64'sd1073741824;
		if (q < -64'sd1073741824) return -64'sd1073741824;
		return q;
	endfunction

	// q in Q2.30 times x, floored by 2^-30
	function automatic longint rot_mul(longint q, longint x);
		longint p;
		p = q * x;
		return p >>> 30;
	endfunction

	// floor(diff * w / 2^16), saturated to 32 bits
	function automatic longint apply_weight(longint diff, longint w);
		longint mag, p;
		if (w == 0) return 0;
		mag = diff < 0 ? -diff : diff;
		if (mag > (64'sd1 <<< 47) / w) return diff < 0 ? -64'sd2147483648 : 64'sd2147483647;
		p = (diff * w) >>> 16;
		if (p > 64'sd2147483647) return 64'sd2147483647;
		if (p < -64'sd2147483648) return -64'sd2147483648;
		return p;
	endfunction

	function automatic residual_t project_point(logic [175:0] d);
		residual_t r;
		longint px, py, pz, ou, ov, w, qx, qy, qz, qw;
		longint ax, ay, az, bx, by, bz, xc, yc, zc, u, v;
		px = longint'($signed(d[31:0]));
		py = longint'($signed(d[63:32]));
		pz = longint'($signed(d[95:64]));
		ou = longint'(d[121:96]);
		ov = longint'(d[147:122]);
		w = longint'(d[171:148]);
		qx = limit_unit(cam_qx);
		qy = limit_unit(cam_qy);
		qz = limit_unit(cam_qz);
		qw = limit_unit(cam_qw);
		// v x p, then v x (v x p)
		ax = rot_mul(qy, pz) - rot_mul(qz, py);
		ay = rot_mul(qz, px) - rot_mul(qx, pz);
		az = rot_mul(qx, py) - rot_mul(qy, px);
		bx = rot_mul(qy, az) - rot_mul(qz, ay);
		by = rot_mul(qz, ax) - rot_mul(qx, az);
		bz = rot_mul(qx, ay) - rot_mul(qy, ax);
		xc = px + 2 * rot_mul(qw, ax) + 2 * bx + cam_tx;
		yc = py + 2 * rot_mul(qw, ay) + 2 * by + cam_ty;
		zc = pz + 2 * rot_mul(qw, az) + 2 * bz + cam_tz;
		if (zc <= 655) begin
			r.res_u = 32'(64'sd100 * w);
			r.res_v = r.res_u;
			r.behind = 1'b1;
		end else begin
			u = (xc * 64'sd24742151) / zc + 64'sd21508481;
			v = (yc * 64'sd24720824) / zc + 64'sd15756616;
			r.res_u = 32'(apply_weight(u - ou, w));
			r.res_v = 32'(apply_weight(v - ov, w));
			r.behind = 1'b0;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		residual_t exp_r;
		if (!arst_n) begin
			cam_tx <= 0;
			cam_ty <= 0;
			cam_tz <= 0;
			cam_qx <= 0;
			cam_qy <= 0;
			cam_qz <= 0;
			cam_qw <= 64'sd1073741824;
			errors <= 0;
			outstanding <= 0;
			pending_residuals.delete();
		end else begin
			// config transaction
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_TRANS_X: cam_tx <= longint'($signed(cfg_data));
					CFG_TRANS_Y: cam_ty <= longint'($signed(cfg_data));
					CFG_TRANS_Z: cam_tz <= longint'($signed(cfg_data));
					CFG_QUAT_X:  cam_qx <= longint'($signed(cfg_data));
					CFG_QUAT_Y:  cam_qy <= longint'($signed(cfg_data));
					CFG_QUAT_Z:  cam_qz <= longint'($signed(cfg_data));
					CFG_QUAT_W:  cam_qw <= longint'($signed(cfg_data));
					default: ;
				endcase
			end
			// result transaction against the oldest expectation
			if (m_tvalid && m_tready) begin
				if (pending_residuals.size() == 0) begin
					$error("residual with none expected: u %h v %h", m_tdata[31:0],
						m_tdata[63:32]);
					errors <= errors + 1;
				end else begin
					exp_r = pending_residuals.pop_front();
					if (m_tdata[31:0] !== exp_r.res_u ||
						m_tdata[63:32] !== exp_r.res_v || m_tuser[0] !== exp_r.behind)
						errors <= errors + 1;
					if (m_tdata[31:0] !== exp_r.res_u)
						$error("residual_u expected %h got %h", exp_r.res_u, m_tdata[31:0]);
					if (m_tdata[63:32] !== exp_r.res_v)
						$error("residual_v expected %h got %h", exp_r.res_v, m_tdata[63:32]);
					if (m_tuser[0] !== exp_r.behind)
						$error("behind_camera expected %b got %b", exp_r.behind, m_tuser[0]);
				end
			end
			// input transaction
			if (s_tvalid && s_tready)
				pending_residuals.insert(pending_residuals.size(), project_point(s_tdata));
			outstanding <= pending_residuals.size();
		end
	end

endmodule

`default_nettype wire

[tb/tb_top.sv]
// testbench top: stimulus, idling, watchdog and verdict for the reprojection residual block
`timescale 1ns / 100ps
`default_nettype none

module tb_top;
	import prr_pkg::*;

	localparam int StallLimit = 5000;
	localparam int DrainWait  = 100;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [175:0] s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [63:0]  m_tdata;
	logic [0:0]   m_tuser;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [2:0]   cfg_index = '0;
	logic [31:0]  cfg_data = '0;
	int           errors, outstanding;
	int           tx_idle_pct = 37;
	int           rx_idle_pct = 81;
	int           hold_req = 0;
	int           hold_taken = 0;
	int           hold_left = 0;
	int           quiet_cycles = 0;

	always #1 clk = ~clk;

	pinhole_reprojection_residual DUT (.*);

	prr_checker checker_i (.*);

	// receiver: random stalls plus long hold-offs on request
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_req != hold_taken) begin
			hold_taken <= hold_req;
			hold_left <= 400;
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= StallLimit) begin
			$display("tb_top: done, errors");
			$finish;
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic write_pose(input logic [31:0] tx, ty, tz, qx, qy, qz, qw);
		write_reg(CFG_TRANS_X, tx);
		write_reg(CFG_TRANS_Y, ty);
		write_reg(CFG_TRANS_Z, tz);
		write_reg(CFG_QUAT_X, qx);
		write_reg(CFG_QUAT_Y, qy);
		write_reg(CFG_QUAT_Z, qz);
		write_reg(CFG_QUAT_W, qw);
	endtask

	task automatic send_obs(input logic [31:0] px, py, pz, input logic [25:0] ou, ov,
		input logic [23:0] w);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {4'b0, w, ov, ou, pz, py, px};
		do @(negedge clk); while (!s_tready);
		@(posedge clk);
	endtask

	// wait until the pipeline is empty before touching the pose
	task automatic drain;
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (DrainWait) @(posedge clk);
	endtask

	function automatic logic [31:0] signed_range(int lo, int hi);
		return 32'($signed($urandom_range(hi - lo)) + lo);
	endfunction

	// mostly plausible observations in front of the camera, some raw noise
	task automatic send_random_obs;
		if ($urandom_range(99) < 20)
			send_obs($urandom, $urandom, $urandom, 26'($urandom), 26'($urandom),
				24'($urandom));
		else
			send_obs(signed_range(-327680, 327680), signed_range(-327680, 327680),
				signed_range(-65536, 1310720), 26'($urandom_range(41943040)),
				26'($urandom_range(31457280)), 24'($urandom_range(262144)));
	endtask

	task automatic random_pose;
		write_pose(signed_range(-131072, 131072), signed_range(-131072, 131072),
			signed_range(-65536, 196608), signed_range(-600000000, 600000000),
			signed_range(-600000000, 600000000), signed_range(-600000000, 600000000),
			signed_range(600000000, 1073741824));
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// identity pose: axis, depth threshold and field extremes
		send_obs(32'd0, 32'd0, 32'd65536, 26'd0, 26'd0, 24'd65536);
		send_obs(32'd65536, -32'sd65536, 32'd131072, 26'h3FFFFFF, 26'h3FFFFFF, 24'hFFFFFF);
		send_obs(32'd0, 32'd0, 32'd655, 26'd100, 26'd100, 24'hFFFFFF);
		send_obs(32'd0, 32'd0, 32'd656, 26'd100, 26'd100, 24'd65536);
		send_obs(32'd0, 32'd0, 32'h80000000, 26'd0, 26'd0, 24'd1);
		send_obs(32'h7FFFFFFF, 32'h80000000, 32'd656, 26'd0, 26'h3FFFFFF, 24'hFFFFFF);
		send_obs(32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 26'h3FFFFFF, 26'd0, 24'hFFFFFF);
		send_obs(32'd1000, 32'd1000, 32'd700, 26'd5, 26'd5, 24'd0);
		send_obs(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 26'h2AAAAAA, 26'h1555555, 24'hAAAAAA);
		drain();

		// quaternion beyond range, saturated translation, ignored index
		write_pose(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
			32'h40000000, 32'h7FFFFFFF);
		write_reg(3'd7, 32'hFFFFFFFF);
		send_obs(32'd0, 32'd0, 32'd0, 26'd0, 26'd0, 24'hFFFFFF);
		send_obs(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 26'h3FFFFFF, 26'h3FFFFFF, 24'h1);
		send_obs(32'h80000000, 32'h80000000, 32'h80000000, 26'd0, 26'd0, 24'hFFFFFF);
		drain();

		// non-unit quaternion at the negative limit
		write_pose(32'd0, 32'd0, 32'd65536, 32'hC0000000, 32'hC0000000, 32'hC0000000,
			32'hC0000000);
		send_obs(32'd65536, 32'd131072, 32'd196608, 26'd1000, 26'd2000, 24'd65536);
		send_obs(32'h80000000, 32'd0, 32'h7FFFFFFF, 26'h3FFFFFF, 26'd0, 24'hFFFFFF);
		drain();

		// random part: three idling modes, several poses each
		for (int mode = 0; mode < 3; mode++) begin
			tx_idle_pct = (mode == 0) ? 37 : (mode == 1) ? 81 : 0;
			rx_idle_pct = (mode == 0) ? 81 : (mode == 1) ? 37 : 0;
			for (int ph = 0; ph < 3; ph++) begin
				if (mode == 2 && ph == 0)
					write_pose(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'h40000000);
				else
					random_pose();
				if (ph == 1) hold_req = hold_req + 1;
				for (int i = 0; i < 55; i++) send_random_obs();
				drain();
			end
		end

		if (errors == 0 && outstanding == 0) begin
			$display("tb_top: done, clean");
		end else begin
			$display("tb_top: done, errors");
		end
		$finish;
	end

endmodule

`default_nettype wire

[sim.f]
hdl/prr_pkg.sv
hdl/prr_div.sv
hdl/pinhole_reprojection_residual.sv
tb/prr_checker.sv
tb/tb_top.sv
